[rtl/core/asdbt_pkg.sv]
// constants and codes shared by the anomaly status debounce and band tracker
`default_nettype none
package asdbt_pkg;

	localparam int NUM_BANDS  = 4;
	localparam int BAND_W     = $clog2(NUM_BANDS);
	localparam int VAL_W      = 24;
	localparam int DIST_W     = 16;
	localparam int RATE_W     = 16;
	localparam int CONF_W     = 4;
	localparam int CMD_W      = 2;
	localparam int STATUS_W   = 2;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 16;

	localparam logic [VAL_W-1:0] MAX24 = {VAL_W{1'b1}};

	localparam logic [DIST_W-1:0] WARN_RESET   = 16'd2001;
	localparam logic [DIST_W-1:0] DANGER_RESET = 16'd2904;
	localparam logic [CONF_W-1:0] CONFIRM_RESET = 4'd5;
	localparam logic [RATE_W-1:0] RATE_RESET   = 16'd655;
	localparam logic [VAL_W-1:0]  VAR_RESET    = 24'd4096;
	localparam logic [CONF_W-1:0] STREAK_MAX   = {CONF_W{1'b1}};

	localparam logic [CMD_W-1:0] CMD_OBSERVE = 2'd0;
	localparam logic [CMD_W-1:0] CMD_LOAD    = 2'd1;
	localparam logic [CMD_W-1:0] CMD_CLEAR   = 2'd2;

	localparam logic [STATUS_W-1:0] ST_NORMAL  = 2'd0;
	localparam logic [STATUS_W-1:0] ST_WARNING = 2'd1;
	localparam logic [STATUS_W-1:0] ST_DANGER  = 2'd2;
	localparam logic [STATUS_W-1:0] ST_IDLE    = 2'd3;

	localparam logic [CFG_IDX_W-1:0] REG_WARN    = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_DANGER  = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_CONFIRM = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_RATE    = 2'd3;

	typedef logic [VAL_W-1:0] band_val_t;

endpackage
`default_nettype wire

[rtl/core/anomaly_status_debounce_band_tracker_core.sv]
// anomaly status debouncer with per-band exponentially weighted mean and variance tracker
//
// Each beat is classified (normal, warning, danger, idle) and debounced by a
// saturating streak counter; with a baseline loaded, the motor running and a
// normal stable status, the four band means and variances are updated through
// one shared 25x25 signed multiplier under a small sequencer, one band after
// another. Input is stalled while an item is in work, so a new beat is taken
// only after the last result has been loaded into the output register; a
// baseline load takes one multiplier pass and one write per band. A finished
// result sits in the output register while the next beat is taken. The
// configuration port is always ready.
`default_nettype none
module anomaly_status_debounce_band_tracker_core (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [asdbt_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [asdbt_pkg::CFG_DATA_W-1:0]  cfg_data,
	input  logic                              in_valid,
	output logic                              in_stall,
	input  logic [asdbt_pkg::CMD_W-1:0]       cmd,
	input  logic [asdbt_pkg::DIST_W-1:0]      distance_sq,
	input  logic                              motor_running,
	input  logic [asdbt_pkg::VAL_W-1:0]       band_value_0,
	input  logic [asdbt_pkg::VAL_W-1:0]       band_value_1,
	input  logic [asdbt_pkg::VAL_W-1:0]       band_value_2,
	input  logic [asdbt_pkg::VAL_W-1:0]       band_value_3,
	input  logic [asdbt_pkg::VAL_W-1:0]       band_std_0,
	input  logic [asdbt_pkg::VAL_W-1:0]       band_std_1,
	input  logic [asdbt_pkg::VAL_W-1:0]       band_std_2,
	input  logic [asdbt_pkg::VAL_W-1:0]       band_std_3,
	output logic                              out_valid,
	input  logic                              out_stall,
	output logic [asdbt_pkg::STATUS_W-1:0]    stable_status,
	output logic [asdbt_pkg::STATUS_W-1:0]    raw_status,
	output logic                              baseline_ready,
	output logic [asdbt_pkg::VAL_W-1:0]       mean_out_0,
	output logic [asdbt_pkg::VAL_W-1:0]       mean_out_1,
	output logic [asdbt_pkg::VAL_W-1:0]       mean_out_2,
	output logic [asdbt_pkg::VAL_W-1:0]       mean_out_3,
	output logic [asdbt_pkg::VAL_W-1:0]       var_out_0,
	output logic [asdbt_pkg::VAL_W-1:0]       var_out_1,
	output logic [asdbt_pkg::VAL_W-1:0]       var_out_2,
	output logic [asdbt_pkg::VAL_W-1:0]       var_out_3
);
	import asdbt_pkg::*;

	typedef enum logic [3:0] {
		S_IDLE,
		S_MUL_MEAN,
		S_MEAN,
		S_MUL_DEV,
		S_DEV,
		S_MUL_ELO,
		S_MUL_EHI,
		S_VAR,
		S_MUL_STD,
		S_LOAD,
		S_DONE
	} state_t;

	state_t state_q;

	logic [DIST_W-1:0]   warn_q;
	logic [DIST_W-1:0]   danger_q;
	logic [CONF_W-1:0]   confirm_q;
	logic [RATE_W-1:0]   rate_q;

	logic [STATUS_W-1:0] pending_q;
	logic [CONF_W-1:0]   streak_q;
	logic [STATUS_W-1:0] confirmed_q;
	logic [STATUS_W-1:0] raw_q;
	logic                ready_q;
	band_val_t           mean_q [NUM_BANDS];
	band_val_t           var_q  [NUM_BANDS];
	logic [BAND_W-1:0]   band_q;

	logic                out_valid_q;
	logic [STATUS_W-1:0] stable_o_q;
	logic [STATUS_W-1:0] raw_o_q;
	logic                ready_o_q;
	band_val_t           mean_o_q [NUM_BANDS];
	band_val_t           var_o_q  [NUM_BANDS];

	band_val_t           x_q   [NUM_BANDS];
	band_val_t           std_q [NUM_BANDS];
	logic signed [49:0]  p_q;
	logic signed [37:0]  e_q;
	logic [35:0]         acc_q;

	band_val_t           x_in   [NUM_BANDS];
	band_val_t           std_in [NUM_BANDS];

	logic                in_acc;
	logic                out_load;
	logic [STATUS_W-1:0] raw_c;
	logic [CONF_W-1:0]   streak_c;
	logic [STATUS_W-1:0] conf_c;
	logic                track_c;

	band_val_t           xv;
	band_val_t           mv;
	band_val_t           vv;
	logic signed [24:0]  diff;
	logic signed [24:0]  w_s;
	logic signed [24:0]  mul_a;
	logic signed [24:0]  mul_b;
	logic signed [49:0]  prod;
	logic signed [49:0]  p_rnd16;
	logic signed [49:0]  p_rnd12;
	logic signed [39:0]  mean_sum;
	logic signed [55:0]  var_t;
	logic signed [55:0]  var_rnd;
	logic signed [39:0]  var_sum;
	logic [37:0]         sq_full;
	band_val_t           mean_new;
	band_val_t           var_new;
	band_val_t           var_load;

	function automatic band_val_t clamp24(input logic signed [39:0] v);
		band_val_t r;
		if (v < 40'sd0) begin
			r = '0;
		end else if (v > $signed({16'b0, MAX24})) begin
			r = MAX24;
		end else begin
			r = v[VAL_W-1:0];
		end
		return r;
	endfunction

	assign x_in[0]   = band_value_0;
	assign x_in[1]   = band_value_1;
	assign x_in[2]   = band_value_2;
	assign x_in[3]   = band_value_3;
	assign std_in[0] = band_std_0;
	assign std_in[1] = band_std_1;
	assign std_in[2] = band_std_2;
	assign std_in[3] = band_std_3;

	assign cfg_ready = 1'b1;
	assign in_stall  = (state_q != S_IDLE);
	assign in_acc    = in_valid && !in_stall;
	assign out_load  = (state_q == S_DONE) && (!out_valid_q || !out_stall);

	// classification and debounce of the incoming beat
	always_comb begin
		if (!motor_running) begin
			raw_c = ST_IDLE;
		end else if (distance_sq <= warn_q) begin
			raw_c = ST_NORMAL;
		end else if (distance_sq <= danger_q) begin
			raw_c = ST_WARNING;
		end else begin
			raw_c = ST_DANGER;
		end
		if (raw_c == pending_q) begin
			streak_c = (streak_q == STREAK_MAX) ? streak_q : streak_q + 1'b1;
		end else begin
			streak_c = {{(CONF_W-1){1'b0}}, 1'b1};
		end
		conf_c  = (streak_c >= confirm_q) ? raw_c : confirmed_q;
		track_c = ready_q && motor_running && (conf_c == ST_NORMAL);
	end

	// shared multiplier and its pre/post arithmetic
	assign xv   = x_q[band_q];
	assign mv   = mean_q[band_q];
	assign vv   = var_q[band_q];
	assign diff = $signed({1'b0, xv}) - $signed({1'b0, mv});
	assign w_s  = $signed({9'b0, rate_q});

	always_comb begin
		case (state_q)
			S_MUL_MEAN: begin
				mul_a = diff;
				mul_b = w_s;
			end
			S_MUL_DEV: begin
				mul_a = diff;
				mul_b = diff;
			end
			S_MUL_ELO: begin
				mul_a = $signed({6'b0, e_q[18:0]});
				mul_b = w_s;
			end
			S_MUL_EHI: begin
				mul_a = $signed({{6{e_q[37]}}, e_q[37:19]});
				mul_b = w_s;
			end
			S_MUL_STD: begin
				mul_a = $signed({1'b0, std_q[band_q]});
				mul_b = $signed({1'b0, std_q[band_q]});
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	assign prod     = mul_a * mul_b;
	assign p_rnd16  = (p_q + 50'sd32768) >>> 16;
	assign p_rnd12  = p_q + 50'sd2048;
	assign sq_full  = p_rnd12[49:12];
	assign mean_sum = $signed({16'b0, mv}) + $signed(p_rnd16[39:0]);
	assign mean_new = clamp24(mean_sum);
	assign var_t    = ($signed({{6{p_q[49]}}, p_q}) <<< 19) + $signed({20'b0, acc_q});
	assign var_rnd  = (var_t + 56'sd32768) >>> 16;
	assign var_sum  = $signed({16'b0, vv}) + $signed(var_rnd[39:0]);
	assign var_new  = clamp24(var_sum);
	assign var_load = (sq_full > {14'b0, MAX24}) ? MAX24 : sq_full[VAL_W-1:0];

	// datapath operand and product registers
	always_ff @(posedge clk) begin
		if (in_acc) begin
			x_q   <= x_in;
			std_q <= std_in;
		end
		p_q <= prod;
		if (state_q == S_DEV) begin
			e_q <= $signed(sq_full) - $signed({14'b0, vv});
		end
		if (state_q == S_MUL_EHI) begin
			acc_q <= p_q[35:0];
		end
	end

	// sequencer, tracker state, configuration and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			warn_q      <= WARN_RESET;
			danger_q    <= DANGER_RESET;
			confirm_q   <= CONFIRM_RESET;
			rate_q      <= RATE_RESET;
			pending_q   <= ST_NORMAL;
			streak_q    <= '0;
			confirmed_q <= ST_NORMAL;
			raw_q       <= ST_NORMAL;
			ready_q     <= 1'b0;
			band_q      <= '0;
			out_valid_q <= 1'b0;
			stable_o_q  <= ST_NORMAL;
			raw_o_q     <= ST_NORMAL;
			ready_o_q   <= 1'b0;
			for (int i = 0; i < NUM_BANDS; i++) begin
				mean_q[i]   <= '0;
				var_q[i]    <= VAR_RESET;
				mean_o_q[i] <= '0;
				var_o_q[i]  <= VAR_RESET;
			end
		end else begin
			if (cfg_valid) begin
				case (cfg_index)
					REG_WARN:    warn_q    <= cfg_data;
					REG_DANGER:  danger_q  <= cfg_data;
					REG_CONFIRM: confirm_q <= cfg_data[CONF_W-1:0];
					REG_RATE:    rate_q    <= cfg_data;
					default:     ;
				endcase
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						band_q <= '0;
						raw_q  <= (cmd == CMD_OBSERVE) ? raw_c : ST_NORMAL;
						case (cmd)
							CMD_OBSERVE: begin
								pending_q   <= raw_c;
								streak_q    <= streak_c;
								confirmed_q <= conf_c;
								state_q     <= track_c ? S_MUL_MEAN : S_DONE;
							end
							CMD_LOAD: begin
								ready_q <= 1'b1;
								state_q <= S_MUL_STD;
							end
							CMD_CLEAR: begin
								ready_q <= 1'b0;
								state_q <= S_DONE;
							end
							default: state_q <= S_DONE;
						endcase
					end
				end
				S_MUL_MEAN: state_q <= S_MEAN;
				S_MEAN: begin
					mean_q[band_q] <= mean_new;
					state_q        <= S_MUL_DEV;
				end
				S_MUL_DEV: state_q <= S_DEV;
				S_DEV:     state_q <= S_MUL_ELO;
				S_MUL_ELO: state_q <= S_MUL_EHI;
				S_MUL_EHI: state_q <= S_VAR;
				S_VAR: begin
					var_q[band_q] <= var_new;
					if (band_q == BAND_W'(NUM_BANDS - 1)) begin
						state_q <= S_DONE;
					end else begin
						band_q  <= band_q + 1'b1;
						state_q <= S_MUL_MEAN;
					end
				end
				S_MUL_STD: state_q <= S_LOAD;
				S_LOAD: begin
					mean_q[band_q] <= xv;
					var_q[band_q]  <= var_load;
					if (band_q == BAND_W'(NUM_BANDS - 1)) begin
						state_q <= S_DONE;
					end else begin
						band_q  <= band_q + 1'b1;
						state_q <= S_MUL_STD;
					end
				end
				S_DONE: begin
					if (out_load) begin
						stable_o_q  <= confirmed_q;
						raw_o_q     <= raw_q;
						ready_o_q   <= ready_q;
						mean_o_q    <= mean_q;
						var_o_q     <= var_q;
						state_q     <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign out_valid      = out_valid_q;
	assign stable_status  = stable_o_q;
	assign raw_status     = raw_o_q;
	assign baseline_ready = ready_o_q;
	assign mean_out_0     = mean_o_q[0];
	assign mean_out_1     = mean_o_q[1];
	assign mean_out_2     = mean_o_q[2];
	assign mean_out_3     = mean_o_q[3];
	assign var_out_0      = var_o_q[0];
	assign var_out_1      = var_o_q[1];
	assign var_out_2      = var_o_q[2];
	assign var_out_3      = var_o_q[3];

	// band walk starts at band zero
	a_band_start: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc |=> (band_q == '0))
		else $error("band counter not cleared at accept");

	// debounced status moves only on an accepted beat
	a_conf_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!in_acc |=> $stable(confirmed_q))
		else $error("stable status changed without a beat");

	// baseline drops only on a clear command
	a_ready_fall: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(ready_q) |-> $past(in_acc && (cmd == CMD_CLEAR)))
		else $error("baseline ready dropped without clear");

	// an observe always leaves a nonzero streak
	a_streak: assert property (@(posedge clk) disable iff (!arst_n)
		(in_acc && (cmd == CMD_OBSERVE)) |=> (streak_q != '0))
		else $error("streak counter zero after observe");

	// variance is only tracked against a loaded baseline
	a_var_ready: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_VAR) |-> ready_q)
		else $error("variance update without baseline");

endmodule
`default_nettype wire

[verif/tb_top.sv]
`timescale 1ns / 1ps
// self-checking testbench for the anomaly status debounce and band tracker core
module tb_top;
	import asdbt_pkg::*;

	localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

	typedef struct packed {
		logic [CMD_W-1:0]                op;
		logic [DIST_W-1:0]               dsq;
		logic                            motor;
		logic [NUM_BANDS-1:0][VAL_W-1:0] level;
		logic [NUM_BANDS-1:0][VAL_W-1:0] sdev;
	} obs_beat_t;

	typedef struct packed {
		logic [STATUS_W-1:0]             stable;
		logic [STATUS_W-1:0]             raw;
		logic                            ready;
		logic [NUM_BANDS-1:0][VAL_W-1:0] mean;
		logic [NUM_BANDS-1:0][VAL_W-1:0] variance;
	} status_beat_t;

	class tracker_scoreboard;
		logic [DIST_W-1:0]   warn_lvl;
		logic [DIST_W-1:0]   danger_lvl;
		logic [CONF_W-1:0]   confirm_need;
		logic [RATE_W-1:0]   rate_w;
		logic [STATUS_W-1:0] pending_st;
		logic [STATUS_W-1:0] stable_st;
		int                  streak;
		logic                ready;
		band_val_t           mean [NUM_BANDS];
		band_val_t           variance [NUM_BANDS];
		status_beat_t        expected_reports [$];
		int                  errors;
		int                  updates;

		function new();
			warn_lvl = WARN_RESET;
			danger_lvl = DANGER_RESET;
			confirm_need = CONFIRM_RESET;
			rate_w = RATE_RESET;
			pending_st = ST_NORMAL;
			stable_st = ST_NORMAL;
			streak = 0;
			ready = 1'b0;
			for (int i = 0; i < NUM_BANDS; i++) begin
				mean[i] = '0;
				variance[i] = VAR_RESET;
			end
			errors = 0;
			updates = 0;
		endfunction

		function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
			case (idx)
			REG_WARN:    warn_lvl = data;
			REG_DANGER:  danger_lvl = data;
			REG_CONFIRM: confirm_need = data[CONF_W-1:0];
			REG_RATE:    rate_w = data;
			default:     ;
			endcase
		endfunction

		// round half up, then divide by 2^k
		function longint round_shr(longint p, int k);
			return (p + (longint'(1) << (k - 1))) >>> k;
		endfunction

		function band_val_t clamp24(longint v);
			if (v < 0)
				return '0;
			if (v > longint'(MAX24))
				return MAX24;
			return band_val_t'(v);
		endfunction

		function void accept_beat(obs_beat_t b);
			status_beat_t        r;
			logic [STATUS_W-1:0] raw;
			longint              x, m, v, d, s, w, sd;
			raw = ST_NORMAL;
			if (b.op == CMD_OBSERVE) begin
				if (!b.motor)
					raw = ST_IDLE;
				else if (b.dsq <= warn_lvl)
					raw = ST_NORMAL;
				else if (b.dsq <= danger_lvl)
					raw = ST_WARNING;
				else
					raw = ST_DANGER;
				if (raw == pending_st) begin
					if (streak < STREAK_MAX)
						streak++;
				end else begin
					pending_st = raw;
					streak = 1;
				end
				if (streak >= confirm_need)
					stable_st = pending_st;
				if (ready && b.motor && stable_st == ST_NORMAL) begin
					updates++;
					w = rate_w;
					for (int i = 0; i < NUM_BANDS; i++) begin
						x = b.level[i];
						m = mean[i];
						v = variance[i];
						m = clamp24(m + round_shr(w * (x - m), 16));
						d = x - m;
						s = round_shr(d * d, 12);
						mean[i] = band_val_t'(m);
						variance[i] = clamp24(v + round_shr(w * (s - v), 16));
					end
				end
			end else if (b.op == CMD_LOAD) begin
				for (int i = 0; i < NUM_BANDS; i++) begin
					sd = b.sdev[i];
					mean[i] = b.level[i];
					variance[i] = clamp24(round_shr(sd * sd, 12));
				end
				ready = 1'b1;
			end else if (b.op == CMD_CLEAR) begin
				ready = 1'b0;
			end
			r.stable = stable_st;
			r.raw = raw;
			r.ready = ready;
			for (int i = 0; i < NUM_BANDS; i++) begin
				r.mean[i] = mean[i];
				r.variance[i] = variance[i];
			end
			expected_reports.push_back(r);
		endfunction

		function void check_beat(status_beat_t got);
			status_beat_t want;
			if (expected_reports.size() == 0) begin
				$error("result beat with no expectation waiting");
				errors++;
				return;
			end
			want = expected_reports.pop_front();
			if (got.stable !== want.stable) begin
				$error("stable_status: expected %0d, actual %0d", want.stable, got.stable);
				errors++;
			end
			if (got.raw !== want.raw) begin
				$error("raw_status: expected %0d, actual %0d", want.raw, got.raw);
				errors++;
			end
			if (got.ready !== want.ready) begin
				$error("baseline_ready: expected %0d, actual %0d", want.ready, got.ready);
				errors++;
			end
			for (int i = 0; i < NUM_BANDS; i++) begin
				if (got.mean[i] !== want.mean[i]) begin
					$error("mean_out_%0d: expected %0d, actual %0d", i, want.mean[i],
						got.mean[i]);
					errors++;
				end
				if (got.variance[i] !== want.variance[i]) begin
					$error("var_out_%0d: expected %0d, actual %0d", i, want.variance[i],
						got.variance[i]);
					errors++;
				end
			end
		endfunction
	endclass

	logic                   clk = 1'b0;
	logic                   arst_n = 1'b0;
	logic                   cfg_valid = 1'b0;
	logic                   cfg_ready;
	logic [CFG_IDX_W-1:0]   cfg_index = '0;
	logic [CFG_DATA_W-1:0]  cfg_data = '0;
	logic                   in_valid = 1'b0;
	logic                   in_stall;
	logic [CMD_W-1:0]       cmd = CMD_OBSERVE;
	logic [DIST_W-1:0]      distance_sq = '0;
	logic                   motor_running = 1'b0;
	logic [VAL_W-1:0]       band_value_0 = '0;
	logic [VAL_W-1:0]       band_value_1 = '0;
	logic [VAL_W-1:0]       band_value_2 = '0;
	logic [VAL_W-1:0]       band_value_3 = '0;
	logic [VAL_W-1:0]       band_std_0 = '0;
	logic [VAL_W-1:0]       band_std_1 = '0;
	logic [VAL_W-1:0]       band_std_2 = '0;
	logic [VAL_W-1:0]       band_std_3 = '0;
	logic                   out_valid;
	logic                   out_stall = 1'b0;
	logic [STATUS_W-1:0]    stable_status;
	logic [STATUS_W-1:0]    raw_status;
	logic                   baseline_ready;
	logic [VAL_W-1:0]       mean_out_0;
	logic [VAL_W-1:0]       mean_out_1;
	logic [VAL_W-1:0]       mean_out_2;
	logic [VAL_W-1:0]       mean_out_3;
	logic [VAL_W-1:0]       var_out_0;
	logic [VAL_W-1:0]       var_out_1;
	logic [VAL_W-1:0]       var_out_2;
	logic [VAL_W-1:0]       var_out_3;

	tracker_scoreboard      sb;
	logic                   burst_mode = 1'b0;
	int                     rx_hold = 0;
	int                     run_left = 0;
	logic [STATUS_W-1:0]    run_target = ST_NORMAL;
	int                     beats = 0;
	int                     loads = 0;
	int                     clears = 0;
	int                     settings = 1;

	anomaly_status_debounce_band_tracker_core dut (.*);

	always #5 clk = ~clk;

	function automatic int idle_draw();
		return burst_mode ? 0 : $urandom_range(0, 3);
	endfunction

	function automatic band_val_t band_draw();
		case ($urandom_range(0, 5))
		0:       return '0;
		1:       return MAX24;
		2:       return band_val_t'($urandom_range(0, 4095));
		3:       return band_val_t'($urandom_range(0, 65535));
		default: return band_val_t'($urandom());
		endcase
	endfunction

	function automatic obs_beat_t beat_of(logic [CMD_W-1:0] op, logic [DIST_W-1:0] dsq,
		logic motor, band_val_t lv, band_val_t sd);
		obs_beat_t b;
		b.op = op;
		b.dsq = dsq;
		b.motor = motor;
		for (int i = 0; i < NUM_BANDS; i++) begin
			b.level[i] = lv;
			b.sdev[i] = sd;
		end
		return b;
	endfunction

	// mostly runs of one status with random content, some commands and noise
	function automatic obs_beat_t make_random_beat();
		obs_beat_t b;
		int        pick;
		int        wl;
		int        dl;
		wl = sb.warn_lvl;
		dl = sb.danger_lvl;
		pick = $urandom_range(0, 99);
		b.op = CMD_OBSERVE;
		b.motor = 1'b1;
		b.dsq = DIST_W'($urandom());
		for (int i = 0; i < NUM_BANDS; i++) begin
			if ($urandom_range(0, 2) == 0)
				b.level[i] = sb.mean[i] + band_val_t'($urandom_range(0, 8191))
					- band_val_t'(4096);
			else
				b.level[i] = band_draw();
			b.sdev[i] = band_draw();
		end
		if (pick < 3) begin
			b.op = CMD_LOAD;
		end else if (pick < 5) begin
			b.op = CMD_CLEAR;
		end else if (pick < 6) begin
			b.op = CMD_UNUSED;
		end else if (pick < 14) begin
			b.motor = 1'($urandom_range(0, 1));
		end else begin
			if (run_left == 0) begin
				case ($urandom_range(0, 9))
				0, 1, 2, 3, 4: run_target = ST_NORMAL;
				5, 6:          run_target = ST_WARNING;
				7:             run_target = ST_DANGER;
				default:       run_target = ST_IDLE;
				endcase
				run_left = $urandom_range(1, 20);
			end
			run_left--;
			case (run_target)
			ST_IDLE:    b.motor = 1'b0;
			ST_NORMAL:  b.dsq = DIST_W'($urandom_range(0, wl));
			ST_WARNING: if (dl > wl) b.dsq = DIST_W'($urandom_range(wl + 1, dl));
			default:    if (dl < 65535) b.dsq = DIST_W'($urandom_range(dl + 1, 65535));
			endcase
		end
		return b;
	endfunction

	// valid drops after each accepted beat, so a stalled payload never changes
	task automatic send_beat(obs_beat_t b);
		int gap;
		gap = idle_draw();
		repeat (gap + 1) @(posedge clk);
		cmd <= b.op;
		distance_sq <= b.dsq;
		motor_running <= b.motor;
		band_value_0 <= b.level[0];
		band_value_1 <= b.level[1];
		band_value_2 <= b.level[2];
		band_value_3 <= b.level[3];
		band_std_0 <= b.sdev[0];
		band_std_1 <= b.sdev[1];
		band_std_2 <= b.sdev[2];
		band_std_3 <= b.sdev[3];
		in_valid <= 1'b1;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		in_valid <= 1'b0;
		sb.accept_beat(b);
		beats++;
		if (b.op == CMD_LOAD)
			loads++;
		if (b.op == CMD_CLEAR)
			clears++;
	endtask

	task automatic drain();
		while (sb.expected_reports.size() != 0) @(posedge clk);
	endtask

	task automatic put_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		sb.set_reg(idx, data);
	endtask

	task automatic program_regs(logic [CFG_DATA_W-1:0] warn, logic [CFG_DATA_W-1:0] danger,
		logic [CFG_DATA_W-1:0] confirm, logic [CFG_DATA_W-1:0] rate);
		put_reg(REG_WARN, warn);
		put_reg(REG_DANGER, danger);
		put_reg(REG_CONFIRM, confirm);
		put_reg(REG_RATE, rate);
		cfg_valid <= 1'b0;
		settings++;
	endtask

	always @(posedge clk) begin : rx_side
		status_beat_t seen;
		if (arst_n && out_valid && !out_stall) begin
			seen.stable = stable_status;
			seen.raw = raw_status;
			seen.ready = baseline_ready;
			seen.mean = {mean_out_3, mean_out_2, mean_out_1, mean_out_0};
			seen.variance = {var_out_3, var_out_2, var_out_1, var_out_0};
			sb.check_beat(seen);
			rx_hold = idle_draw();
		end else if (rx_hold > 0) begin
			rx_hold--;
		end
		out_stall <= (rx_hold > 0);
	end

	initial begin
		#5_000_000;
		$display("timeout: run did not finish");
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

	initial begin
		obs_beat_t b;
		sb = new();
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed beats under the reset settings
		send_beat(beat_of(CMD_OBSERVE, 16'hFFFF, 1'b0, MAX24, '0));
		send_beat(beat_of(CMD_UNUSED, 16'h1234, 1'b1, 24'hABCDEF, MAX24));
		send_beat(beat_of(CMD_CLEAR, '0, 1'b1, '0, '0));
		b = beat_of(CMD_LOAD, 16'hFFFF, 1'b1, '0, '0);
		b.level = {MAX24, 24'h800000, 24'd1234567, 24'd0};
		b.sdev = {24'h123456, VAR_RESET, MAX24, 24'd0};
		send_beat(b);
		for (int k = 0; k < 4; k++)
			send_beat(beat_of(CMD_OBSERVE, '0, 1'b1, k[0] ? MAX24 : '0, k[1] ? MAX24 : '0));
		send_beat(beat_of(CMD_OBSERVE, WARN_RESET, 1'b1, 24'd70000, '0));
		send_beat(beat_of(CMD_OBSERVE, WARN_RESET + 1'b1, 1'b1, 24'd70000, '0));
		send_beat(beat_of(CMD_OBSERVE, DANGER_RESET, 1'b1, 24'd70000, '0));
		send_beat(beat_of(CMD_OBSERVE, DANGER_RESET + 1'b1, 1'b1, 24'd70000, '0));
		for (int k = 0; k < 12; k++)
			send_beat(beat_of(CMD_OBSERVE, 16'hFFFF, 1'b1, band_draw(), band_draw()));
		drain();

		for (int ph = 0; ph < 6; ph++) begin
			case (ph)
			0:       program_regs('0, '0, 16'd1, 16'hFFFF);
			1:       program_regs(16'hFFFF, 16'hFFFF, 16'hFFFF, '0);
			2:       program_regs(16'd3000, 16'd1000, 16'hFFF0, 16'd1);
			5:       program_regs(WARN_RESET, DANGER_RESET, 16'(CONFIRM_RESET), RATE_RESET);
			default: program_regs(16'($urandom_range(0, 4095)), 16'($urandom_range(0, 8191)),
				16'($urandom()), 16'($urandom()));
			endcase
			burst_mode = (ph == 3);
			run_left = 0;
			for (int k = 0; k < 240; k++)
				send_beat(make_random_beat());
			drain();
		end
		burst_mode = 1'b0;
		repeat (40) @(posedge clk);

		$display("Covered %0d input beats over %0d register settings: %0d loads, %0d clears,",
			beats, settings, loads, clears);
		$display("and %0d tracker updates with random gaps and stalls on both sides.",
			sb.updates);
		if (sb.errors == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
